[hw/rtl/ba256_pkg.sv]
// Package for the bearing angle unit: widths, turn constants, arctangent table.
// No dependencies; every other file of the block imports it.
package ba256_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int ANGLE_STAGES_DEF = 16;
  localparam int TAB_LEN          = 32;

  // datapath widths
  localparam int CORDIC_W  = 62;  // signed x/y, magnitudes stay below 2^60
  localparam int ACC_W     = 32;  // signed angle accumulator, 2^-32 turns
  localparam int OCT_W     = 30;  // octant angle, 0 .. 2^29
  localparam int BEAR_W    = 16;
  localparam int SCALE_TOP = 58;  // magnitudes are scaled to just below 2^58

  localparam logic [31:0] TURN_EIGHTH  = 32'h2000_0000;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF    = 32'h8000_0000;

  localparam logic [BEAR_W-1:0] BEAR_UP   = 16'h4000;
  localparam logic [BEAR_W-1:0] BEAR_DOWN = 16'hC000;

  // side information that rides along with each request
  typedef struct packed {
    logic vert;       // dx is zero
    logic vert_down;  // dx zero and dy positive
    logic flat;       // dy is zero
    logic diag;       // |dx| equals |dy|
    logic swap;       // |dy| > |dx|, octant mirrored
    logic dx_neg;
    logic dy_neg;
  } ba256_flags_t;

  // atan(2^-i) in 2^-32 turns, truncated
  function automatic logic [31:0] atan_tab(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/ba256_intf.sv]
// Valid/ready channel interfaces for the bearing angle unit.
// Depends on ba256_pkg for default widths.
interface ba256_in_if
  import ba256_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] from_x;
  logic [COORD_BITS-1:0] from_y;
  logic [COORD_BITS-1:0] to_x;
  logic [COORD_BITS-1:0] to_y;

  modport source (output valid, from_x, from_y, to_x, to_y, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, output ready);
endinterface

interface ba256_out_if
  import ba256_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BEAR_W-1:0] bearing;

  modport source (output valid, bearing, input ready);
  modport sink   (input valid, bearing, output ready);
endinterface

[hw/rtl/bearing_angle_256_unit.sv]
// Top level of the bearing angle unit: point pair in, binary-angle bearing out.
// Depends on ba256_pkg, ba256_intf (channels) and ba256_cordic_stage.
//
//  channel | dir | payload                               | handshake
//  --------+-----+---------------------------------------+------------------
//  in_ch   | in  | from_x, from_y, to_x, to_y            | valid/ready
//  out_ch  | out | bearing (1/65536 turn, 8.8 of 256)    | valid/ready
//
// Throughput: one request per cycle while the skid entry is empty. Pipeline order:
// the differences are registered at the accepting edge, then octant fold, then
// NSTG = min(ANGLE_STAGES + 8, 32) CORDIC rotation stages (a 62-bit add/sub pair
// each), then clamp, then quadrant unfold into the output register.
// Reset (rst_n low, synchronous) clears the valid bits only.
// An output register plus a one-entry skid register sit behind the pipe;
// the pipe freezes only when the skid entry is full, so nothing is dropped.
module bearing_angle_256_unit
  import ba256_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ba256_in_if.sink     in_ch,
  ba256_out_if.source  out_ch
);

  localparam int NSTG     = (ANGLE_STAGES + 8 > TAB_LEN) ? TAB_LEN : ANGLE_STAGES + 8;
  localparam int SCALE_SH = SCALE_TOP - COORD_BITS;

  logic en;

  // ---------------- stage A: differences and magnitudes ----------------
  logic                  va_r;
  logic [COORD_BITS-1:0] ax_r, ay_r, ax_nxt, ay_nxt;
  logic                  dxn_r, dyn_r, dxn_nxt, dyn_nxt;

  always_comb begin
    dxn_nxt = in_ch.to_x < in_ch.from_x;
    dyn_nxt = in_ch.to_y < in_ch.from_y;
    ax_nxt  = dxn_nxt ? in_ch.from_x - in_ch.to_x : in_ch.to_x - in_ch.from_x;
    ay_nxt  = dyn_nxt ? in_ch.from_y - in_ch.to_y : in_ch.to_y - in_ch.from_y;
  end

  // ---------------- stage B: classify, fold into first octant ----------
  logic                       vb_r;
  logic signed [CORDIC_W-1:0] x0_r, y0_r, x0_nxt, y0_nxt;
  ba256_flags_t               flb_r, flb_nxt;

  always_comb begin
    flb_nxt.vert      = (ax_r == '0);
    flb_nxt.vert_down = (ax_r == '0) && (ay_r != '0) && !dyn_r;
    flb_nxt.flat      = (ay_r == '0);
    flb_nxt.diag      = (ax_r == ay_r);
    flb_nxt.swap      = (ay_r > ax_r);
    flb_nxt.dx_neg    = dxn_r;
    flb_nxt.dy_neg    = dyn_r;
    if (flb_nxt.swap) begin
      x0_nxt = CORDIC_W'(ay_r) << SCALE_SH;
      y0_nxt = CORDIC_W'(ax_r) << SCALE_SH;
    end else begin
      x0_nxt = CORDIC_W'(ax_r) << SCALE_SH;
      y0_nxt = CORDIC_W'(ay_r) << SCALE_SH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_ch.valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
      dxn_r <= dxn_nxt;
      dyn_r <= dyn_nxt;
      x0_r  <= x0_nxt;
      y0_r  <= y0_nxt;
      flb_r <= flb_nxt;
    end
  end

  // ---------------- CORDIC rotation pipe ----------------
  logic                       v_s   [0:NSTG];
  logic signed [CORDIC_W-1:0] x_s   [0:NSTG];
  logic signed [CORDIC_W-1:0] y_s   [0:NSTG];
  logic signed [ACC_W-1:0]    acc_s [0:NSTG];
  ba256_flags_t               flg_s [0:NSTG];

  assign v_s[0]   = vb_r;
  assign x_s[0]   = x0_r;
  assign y_s[0]   = y0_r;
  assign acc_s[0] = '0;
  assign flg_s[0] = flb_r;

  for (genvar k = 0; k < NSTG; k++) begin : g_rot
    ba256_cordic_stage #(
      .STAGE_IDX (k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (v_s[k]),
      .x_in    (x_s[k]),
      .y_in    (y_s[k]),
      .acc_in  (acc_s[k]),
      .flg_in  (flg_s[k]),
      .v_out   (v_s[k+1]),
      .x_out   (x_s[k+1]),
      .y_out   (y_s[k+1]),
      .acc_out (acc_s[k+1]),
      .flg_out (flg_s[k+1])
    );
  end

  // ---------------- stage C: clamp and first-quadrant angle ----------
  logic               vc_r;
  logic [31:0]        t_r, t_nxt;
  ba256_flags_t       flc_r;
  logic [OCT_W-1:0]   oct;
  logic signed [ACC_W-1:0] acc_end;

  assign acc_end = acc_s[NSTG];

  always_comb begin
    // octant angle clamped to [0, 1/8 turn]
    if (acc_end[ACC_W-1]) begin
      oct = '0;
    end else if (acc_end > $signed(ACC_W'(TURN_EIGHTH))) begin
      oct = OCT_W'(TURN_EIGHTH);
    end else begin
      oct = acc_end[OCT_W-1:0];
    end
    if (flg_s[NSTG].flat) begin
      t_nxt = '0;
    end else if (flg_s[NSTG].diag) begin
      t_nxt = TURN_EIGHTH;
    end else if (flg_s[NSTG].swap) begin
      t_nxt = TURN_QUARTER - 32'(oct);
    end else begin
      t_nxt = 32'(oct);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= v_s[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= t_nxt;
      flc_r <= flg_s[NSTG];
    end
  end

  // ---------------- quadrant unfold ----------------
  logic [31:0]       full;
  logic [BEAR_W-1:0] bear_nxt;

  always_comb begin
    if (!flc_r.dx_neg) begin
      full = flc_r.dy_neg ? t_r : 32'h0 - t_r;
    end else begin
      full = flc_r.dy_neg ? TURN_HALF - t_r : TURN_HALF + t_r;
    end
    if (flc_r.vert) begin
      bear_nxt = flc_r.vert_down ? BEAR_DOWN : BEAR_UP;
    end else begin
      bear_nxt = full[31:16];
    end
  end

  // ---------------- output register and skid entry ----------------
  logic              out_valid_r, skid_valid_r;
  logic [BEAR_W-1:0] out_bear_r, skid_bear_r;
  logic              take, push;

  assign en   = !skid_valid_r;
  assign take = out_valid_r && out_ch.ready;
  assign push = en && vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // pipe frozen; drain the parked request first
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_bear_r <= skid_bear_r;
      end
    end else if (push) begin
      if (out_valid_r && !take) begin
        skid_bear_r <= bear_nxt;
      end else begin
        out_bear_r <= bear_nxt;
      end
    end
  end

  assign in_ch.ready    = en;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.bearing = out_bear_r;

endmodule

[hw/rtl/ba256_cordic_stage.sv]
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on ba256_pkg (widths, arctangent table, flag struct).
module ba256_cordic_stage
  import ba256_pkg::*;
#(
  parameter int STAGE_IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       v_in,
  input  logic signed [CORDIC_W-1:0] x_in,
  input  logic signed [CORDIC_W-1:0] y_in,
  input  logic signed [ACC_W-1:0]    acc_in,
  input  ba256_flags_t               flg_in,
  output logic                       v_out,
  output logic signed [CORDIC_W-1:0] x_out,
  output logic signed [CORDIC_W-1:0] y_out,
  output logic signed [ACC_W-1:0]    acc_out,
  output ba256_flags_t               flg_out
);

  localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_tab(STAGE_IDX));

  logic                       v_r;
  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  ba256_flags_t               flg_r;

  assign xs = x_in >>> STAGE_IDX;
  assign ys = y_in >>> STAGE_IDX;

  // rotate towards the x axis by the sign of y
  always_comb begin
    if (!y_in[CORDIC_W-1]) begin
      x_nxt   = x_in + ys;
      y_nxt   = y_in - xs;
      acc_nxt = acc_in + ANG;
    end else begin
      x_nxt   = x_in - ys;
      y_nxt   = y_in + xs;
      acc_nxt = acc_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      acc_r <= acc_nxt;
      flg_r <= flg_in;
    end
  end

  assign v_out   = v_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign acc_out = acc_r;
  assign flg_out = flg_r;

endmodule

[tb/bearing_angle_256_unit_tb.sv]
// Testbench for bearing_angle_256_unit: directed and random point pairs against a CORDIC predictor.
// Depends on ba256_pkg and the ba256_in_if / ba256_out_if channel interfaces.
`timescale 1ns / 100ps

module bearing_angle_256_unit_tb;
  import ba256_pkg::*;

  typedef logic [COORD_BITS_DEF-1:0] coord_t;
  typedef logic [BEAR_W-1:0]         bearing_t;

  // exact marks answers with no rounding freedom (vertical, horizontal, diagonal)
  typedef struct {
    bearing_t bearing;
    bit       exact;
  } bearing_exp_t;

  localparam int CORDIC_STEPS = (ANGLE_STAGES_DEF + 8 > TAB_LEN) ? TAB_LEN
                                                                 : ANGLE_STAGES_DEF + 8;
  localparam int PIPE_LATENCY = CORDIC_STEPS + 4;
  localparam int PRE_SHIFT    = SCALE_TOP - COORD_BITS_DEF;
  localparam longint OCTANT_MAX = 64'h2000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;

  // atan(2^-i) in 2^-32 turns, truncated
  localparam logic [0:31][31:0] ARCTAN_TURNS = {
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

  logic clk;
  logic rst_n;

  ba256_in_if  in_ch ();
  ba256_out_if out_ch ();

  bearing_angle_256_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bearing_exp_t expected_bearings[$];
  int           fail_count      = 0;
  bit           sender_idle     = 1'b1;
  bit           sink_idle       = 1'b1;
  int           hold_off_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("bearing_angle_256_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // vectoring CORDIC on a first-octant vector, 0 < tiny < big; angle in 2^-32 turns
  function automatic logic [31:0] octant_turns(input logic [63:0] big, input logic [63:0] tiny);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] xs;
    logic [63:0] ys;
    longint      acc;
    x   = big << PRE_SHIFT;
    y   = tiny << PRE_SHIFT;
    acc = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >> i;
      ys = $signed(y) >>> i;
      if (!y[63]) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + longint'({32'd0, ARCTAN_TURNS[i]});
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - longint'({32'd0, ARCTAN_TURNS[i]});
      end
    end
    if (acc < 0) acc = 0;
    if (acc > OCTANT_MAX) acc = OCTANT_MAX;
    return acc[31:0];
  endfunction

  function automatic bearing_t predict_bearing(input coord_t x1, input coord_t y1,
                                               input coord_t x2, input coord_t y2,
                                               output bit exact);
    bit          dx_neg;
    bit          dy_neg;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [31:0] t;
    logic [31:0] full;
    dx_neg = x2 < x1;
    dy_neg = y2 < y1;
    ax     = dx_neg ? 64'(x1) - 64'(x2) : 64'(x2) - 64'(x1);
    ay     = dy_neg ? 64'(y1) - 64'(y2) : 64'(y2) - 64'(y1);
    exact  = (ax == 0) || (ay == 0) || (ax == ay);
    if (ax == 0) return (ay == 0 || dy_neg) ? BEAR_UP : BEAR_DOWN;
    if (ay == 0)      t = '0;
    else if (ax == ay) t = EIGHTH_TURN;
    else if (ay > ax) t = QUARTER_TURN - octant_turns(ay, ax);
    else              t = octant_turns(ax, ay);
    // screen y points down, so the up component is -dy
    if (!dx_neg) full = dy_neg ? t : 32'd0 - t;
    else         full = dy_neg ? HALF_TURN - t : HALF_TURN + t;
    return full[31:16];
  endfunction

  // ------------------------------------------------------------ shared pieces

  // idle length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one request and wait for it to be taken; entered and left at a rising edge
  task automatic send_request(input coord_t fx, input coord_t fy,
                              input coord_t tx, input coord_t ty);
    int           gap;
    bearing_exp_t exp_item;
    exp_item.bearing = predict_bearing(fx, fy, tx, ty, exp_item.exact);
    gap = sender_idle ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.from_x <= fx;
    in_ch.from_y <= fy;
    in_ch.to_x   <= tx;
    in_ch.to_y   <= ty;
    do @(posedge clk); while (!in_ch.ready);
    expected_bearings.push_back(exp_item);
  endtask

  // result sink: random stalls, or a long hold-off when one is requested
  initial begin : result_sink
    int stall_len;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        stall_len       = hold_off_cycles;
        hold_off_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end else begin
        stall_len = sink_idle ? gap_len() : 0;
        if (stall_len == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (stall_len - 1) @(posedge clk);
        end
      end
    end
  end

  // every accepted result against the oldest outstanding request
  always @(posedge clk) begin : check_result
    bearing_exp_t head;
    bearing_t     diff;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bearings.size() == 0) begin
        $error("bearing: result %h with no request outstanding", out_ch.bearing);
        fail_count++;
      end else begin
        head = expected_bearings.pop_front();
        diff = out_ch.bearing - head.bearing;
        // one LSB either way is allowed where the angle gets rounded
        if (!(diff == 0 || (!head.exact && (diff == 16'h0001 || diff == 16'hFFFF)))) begin
          $error("bearing mismatch: expected %h, actual %h", head.bearing, out_ch.bearing);
          fail_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_directed();
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero vector
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // zero vector, all ones
    send_request(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);  // straight down
    send_request(16'h1234, 16'hFFFF, 16'h1234, 16'h0000);  // straight up
    send_request(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);  // east
    send_request(16'hFFFF, 16'h8000, 16'h0000, 16'h8000);  // west
    send_request(16'h0000, 16'h0000, 16'h0064, 16'h0064);  // diagonals, each quadrant
    send_request(16'h0064, 16'h0064, 16'h0000, 16'h0000);
    send_request(16'h0000, 16'h0064, 16'h0064, 16'h0000);
    send_request(16'h0064, 16'h0000, 16'h0000, 16'h0064);
    send_request(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);  // full-range diagonals
    send_request(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_request(16'h0000, 16'h0000, 16'hFFFF, 16'h0001);  // just below east, wraps near 0
    send_request(16'h0000, 16'h0001, 16'hFFFF, 16'h0000);  // just above east
    send_request(16'h0000, 16'h0000, 16'h0001, 16'hFFFF);  // steep, mirrored octant
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'h0000);
    send_request(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFE);  // one off the diagonal
    send_request(16'h0000, 16'h0000, 16'hFFFE, 16'hFFFF);
    send_request(16'h0000, 16'h0000, 16'h0001, 16'h0000);  // unit steps
    send_request(16'h0001, 16'h0000, 16'h0000, 16'h0001);
    send_request(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    send_request(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    send_request(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8001);
  endtask

  task automatic random_request();
    coord_t fx, fy, tx, ty;
    int     mode;
    int     d;
    int     e;
    mode = $urandom_range(0, 9);
    fx = coord_t'($urandom); fy = coord_t'($urandom);
    tx = coord_t'($urandom); ty = coord_t'($urandom);
    case (mode)
      4: begin  // nearby points
        tx = fx + coord_t'($urandom_range(0, 32)) - coord_t'(16);
        ty = fy + coord_t'($urandom_range(0, 32)) - coord_t'(16);
      end
      5: begin  // on an axis
        if ($urandom_range(0, 1)) tx = fx; else ty = fy;
      end
      6, 7: begin  // on or near a diagonal
        d  = $urandom_range(3, 65535);
        e  = (mode == 7) ? d + $urandom_range(0, 4) - 2 : d;
        if (e > 65535) e = 65535;
        fx = coord_t'($urandom_range(0, 65535 - d)); tx = fx + coord_t'(d);
        fy = coord_t'($urandom_range(0, 65535 - e)); ty = fy + coord_t'(e);
        if ($urandom_range(0, 1)) begin fx = fx ^ tx; tx = fx ^ tx; fx = fx ^ tx; end
        if ($urandom_range(0, 1)) begin fy = fy ^ ty; ty = fy ^ ty; fy = fy ^ ty; end
      end
      8: begin  // coordinates at the ends of their range
        if ($urandom_range(0, 2) == 0) fx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 2) == 0) fy = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 2) == 0) tx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if ($urandom_range(0, 2) == 0) ty = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      9: begin  // one component tiny
        if ($urandom_range(0, 1)) ty = fy + coord_t'($urandom_range(1, 3));
        else                      tx = fx - coord_t'($urandom_range(1, 3));
      end
      default: ;  // fully random
    endcase
    send_request(fx, fy, tx, ty);
  endtask

  task automatic test_random(input int count);
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    repeat (count) random_request();
  endtask

  // back-to-back requests with the sink always ready
  task automatic test_steady(input int count);
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    repeat (count) random_request();
  endtask

  // long sink hold-off while requests keep coming, so the pipe fills and stalls its input
  task automatic test_backpressure();
    sender_idle     = 1'b0;
    sink_idle       = 1'b1;
    hold_off_cycles = 4 * PIPE_LATENCY + 40;
    repeat (120) random_request();
    sender_idle = 1'b1;
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.from_x <= '0;
    in_ch.from_y <= '0;
    in_ch.to_x   <= '0;
    in_ch.to_y   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(1350);
    test_steady(250);
    test_backpressure();
    test_random(50);

    in_ch.valid <= 1'b0;
    while (expected_bearings.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    if (fail_count == 0) begin
      $display("bearing_angle_256_unit test passed");
    end else begin
      $display("bearing_angle_256_unit test failed");
    end
    $finish;
  end

endmodule
